// ===== hdl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

   // Fixed field widths of the request and response beats.
   localparam int OP_W        = 3;
   localparam int POS_W       = 7;
   localparam int ENTRY_W     = 32;
   localparam int RD_W        = 32;
   localparam int LEN_W       = 7;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;
   localparam int REQ_FIELD_W = OP_W + POS_W + ENTRY_W;

   typedef enum logic [OP_W-1:0] {
      OP_GET     = 3'd0,
      OP_INSERT  = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_REPLACE = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   // Response fields, packed so that ok sits in the lowest bit.
   typedef struct packed {
      logic             empty_res;
      logic [LEN_W-1:0] length;
      logic [RD_W-1:0]  read_data;
      logic             ok;
   } rsp_type;

   localparam int RSP_FIELD_W = $bits(rsp_type);

endpackage

// ===== hdl/ple_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ple_seq.sv =====
// Operation sequencer with the shared index stepper and compare of the list engine.
`timescale 1ns / 1ps

module ple_seq
   import ple_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [OP_W-1:0]             req_op,
   input  logic [POS_W-1:0]            req_position,
   input  logic [ENTRY_W-1:0]          req_entry,
   output logic                        res_valid,
   output rsp_type                     res,
   input  logic                        out_free,
   output logic                        ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
   output logic [DATA_WIDTH-1:0]       ram_wr_data,
   output logic                        ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
   input  logic [DATA_WIDTH-1:0]       ram_rd_data
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_SHIFT = 5'b00100,
      S_MOVE  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         limit_ff, limit_in;
   logic                  up_ff, up_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  ok_ff, ok_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;

   logic [CMPW-1:0]            pos_x;
   logic [CMPW-1:0]            cnt_x;
   logic                       pos_nz;
   logic                       in_list;
   logic                       ins_ok;
   logic [AW-1:0]              idx;
   logic [AW-1:0]              ptr_step;
   logic                       at_limit;
   logic [ENTRY_W+DATA_WIDTH-1:0] entry_ext;
   logic [DATA_WIDTH+RD_W-1:0]    rd_ext;
   logic [CW+LEN_W-1:0]           cnt_ext;

   // Request decode: position checks against the current length.
   assign pos_x   = CMPW'(req_position);
   assign cnt_x   = CMPW'(count_ff);
   assign pos_nz  = (req_position != '0);
   assign in_list = pos_nz && (pos_x <= cnt_x);
   assign ins_ok  = pos_nz && (pos_x <= cnt_x + CMPW'(1)) && (cnt_x != CMPW'(CAPACITY));
   assign idx     = AW'(pos_x - CMPW'(1));

   assign entry_ext = {{DATA_WIDTH{1'b0}}, req_entry};

   // The shared unit: one incrementer/decrementer and one equality compare.
   assign ptr_step = up_ff ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
   assign at_limit = (ptr_ff == limit_ff);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      ptr_in      = ptr_ff;
      limit_in    = limit_ff;
      up_in       = up_ff;
      word_in     = word_ff;
      count_in    = count_ff;
      ok_in       = ok_ff;
      rd_in       = rd_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff;
      ram_wr_data = word_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_step;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_op;
               word_in = entry_ext[DATA_WIDTH-1:0];
               rd_in   = '0;
               ok_in   = 1'b0;
               ptr_in  = idx;
               state_in = S_RESP;
               unique case (req_op) inside
                  OP_GET, OP_REPLACE: begin
                     if (in_list) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx;
                        state_in    = S_FETCH;
                     end
                  end
                  OP_INSERT: begin
                     if (ins_ok) begin
                        ptr_in   = AW'(count_ff);
                        limit_in = idx;
                        up_in    = 1'b0;
                        state_in = S_SHIFT;
                     end
                  end
                  OP_REMOVE: begin
                     if (in_list) begin
                        limit_in = AW'(count_ff - CW'(1));
                        up_in    = 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_FETCH: begin
            rd_in = ram_rd_data;
            ok_in = 1'b1;
            if (op_ff == OP_REPLACE) begin
               ram_wr_en = 1'b1;
            end
            state_in = S_RESP;
         end
         S_SHIFT: begin
            if (at_limit) begin
               if (up_ff) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
               ok_in    = 1'b1;
               state_in = S_RESP;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_MOVE;
            end
         end
         S_MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            ptr_in      = ptr_step;
            state_in    = S_SHIFT;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff    <= op_in;
      ptr_ff   <= ptr_in;
      limit_ff <= limit_in;
      up_ff    <= up_in;
      word_ff  <= word_in;
      ok_ff    <= ok_in;
      rd_ff    <= rd_in;
   end

   assign rd_ext  = {{RD_W{1'b0}}, rd_ff};
   assign cnt_ext = {{LEN_W{1'b0}}, count_ff};

   assign req_ready     = (state_ff == S_IDLE);
   assign res_valid     = (state_ff == S_RESP);
   assign res.ok        = ok_ff;
   assign res.read_data = rd_ext[RD_W-1:0];
   assign res.length    = cnt_ext[LEN_W-1:0];
   assign res.empty_res = (count_ff == '0);

   // The length never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= CMPW'(CAPACITY))
      else $error("list length exceeds capacity");

   // The RAM is never read and written in the same cycle.
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM read and write collide");

   // The shift pointer stays on its side of the stop index.
   a_ptr_side: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (up_ff ? (ptr_ff <= limit_ff) : (ptr_ff >= limit_ff)))
      else $error("shift pointer ran past its limit");

   // A result handed to the output register frees the sequencer.
   a_resp_leave: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) && out_free |=> (state_ff == S_IDLE))
      else $error("sequencer stuck after result hand-off");

   // A move always writes back the word it just read.
   a_move_wr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |-> ram_wr_en && $past(ram_rd_en))
      else $error("move step without its read");

endmodule

// ===== hdl/positional_list_engine.sv =====
// Top level of the positional list engine: stream ports, list storage and result register.
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to CAPACITY words addressed by 1-based
// position and runs one operation per request beat (get, insert, remove, replace,
// clear), answering each with exactly one response beat that carries ok, the word
// read, the new length and an empty flag. Entries live in a single-port-per-side
// RAM with a registered read, and every entry move goes through that one read and
// one write port, so the cost of an operation is set by that RAM: each entry that an
// insert or remove moves is read in S_SHIFT and written in S_MOVE, and a get or
// replace fetches its word in S_FETCH; a bad request or a clear goes straight to
// S_RESP. The engine holds req_tready low while an operation is in progress, but
// it takes the next request while an earlier response still waits in the output
// register. After reset the list is empty; no clearing pass is needed because only
// entries below the current length are ever read.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // op [2:0], position [9:3], entry [41:10], zero fill above.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // ok [0], read_data [32:1], length [39:33], empty_res [40], zero fill above.
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);

   logic                  res_valid;
   rsp_type               res;
   logic                  out_free;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // The sequencer steps through each operation and drives the RAM ports.
   ple_seq #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tdata[OP_W-1:0]),
      .req_position(req_tdata[OP_W+POS_W-1:OP_W]),
      .req_entry   (req_tdata[REQ_FIELD_W-1:OP_W+POS_W]),
      .res_valid   (res_valid),
      .res         (res),
      .out_free    (out_free),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // List storage; position p lives at address p-1.
   ple_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(CAPACITY)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // The output register is free when empty or when its beat leaves this cycle.
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && out_free) || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = (res_valid && out_free) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, rsp_ff};

endmodule

// ===== sim/positional_list_engine_test.sv =====
// Self-checking testbench for the positional list engine with directed and random stimulus.
`timescale 1ns / 1ps

module positional_list_engine_test;
   import ple_pkg::*;

   // The block under test is built with its default size, so the local copy of the
   // list below holds the same number of entries.
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   // Operation codes that the engine does not implement; each must be refused.
   localparam logic [OP_W-1:0] OP_BAD_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_BAD_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_BAD_HI  = 3'd7;

   // The slowest operation is an insert at the head of a list one short of full, since
   // every other entry moves. The drain wait at the end covers that, and the watchdog
   // allows several times the slowest whole run.
   localparam int DRAIN_CYCLES = 2 * (CAPACITY + 1) + 20;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1450;

   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_BALANCED
   } op_mix_type;

   // One row of the directed table. Where has_answer is set, the answer typed into
   // the row is the expected response; otherwise the local list model decides.
   typedef struct {
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   position;
      logic [ENTRY_W-1:0] entry;
      bit                 has_answer;
      rsp_type            answer;
   } list_request_row;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // op [2:0], position [9:3], entry [41:10], zero fill above.
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // ok [0], read_data [32:1], length [39:33], empty_res [40], zero fill above.
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Local copy of the list: the words in position order and the current length.
   logic [ENTRY_W-1:0] list_words [CAPACITY];
   int                 list_len = 0;

   // Responses still owed by the engine, oldest first.
   rsp_type            owed_responses [$];
   list_request_row    directed_rows [$];

   int  error_count    = 0;
   int  cycle_count    = 0;
   int  requests_sent  = 0;
   int  responses_seen = 0;
   bit  stimulus_done  = 1'b0;

   positional_list_engine #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Applies one operation to the local list and returns the response the engine
   // must give. Positions are 1-based; position p lives in list_words[p-1].
   function automatic rsp_type apply_list_op(input logic [OP_W-1:0]    op_code,
                                             input logic [POS_W-1:0]   position,
                                             input logic [ENTRY_W-1:0] word);
      rsp_type answer;
      int      pos;
      bit      in_list;
      answer  = '0;
      pos     = int'(position);
      in_list = (pos >= 1) && (pos <= list_len);
      case (op_code)
         OP_GET: begin
            if (in_list) begin
               answer.read_data = list_words[pos-1];
               answer.ok        = 1'b1;
            end
         end
         OP_INSERT: begin
            // Entries from the position onward move up one place to open a gap.
            if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
               for (int i = list_len; i > pos - 1; i--)
                  list_words[i] = list_words[i-1];
               list_words[pos-1] = word;
               list_len++;
               answer.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            // Later entries move down one place to close the gap.
            if (in_list) begin
               for (int i = pos - 1; i + 1 < list_len; i++)
                  list_words[i] = list_words[i+1];
               list_len--;
               answer.ok = 1'b1;
            end
         end
         OP_REPLACE: begin
            if (in_list) begin
               answer.read_data  = list_words[pos-1];
               list_words[pos-1] = word;
               answer.ok         = 1'b1;
            end
         end
         OP_CLEAR: begin
            list_len  = 0;
            answer.ok = 1'b1;
         end
         default: begin
         end
      endcase
      answer.length    = list_len[LEN_W-1:0];
      answer.empty_res = (list_len == 0);
      return answer;
   endfunction

   // Idle cycles before a beat. Every fourth stretch of forty beats runs with no
   // idling at all, so back-to-back traffic is covered on both sides.
   function automatic int draw_idle(input int beat_index);
      if ((beat_index / 40) % 4 == 3)
         return 0;
      return $urandom_range(0, 6);
   endfunction

   // The flags of a row are given as 0 or 1.
   function automatic list_request_row make_row(input logic [OP_W-1:0]    op,
                                                input logic [POS_W-1:0]   position,
                                                input logic [ENTRY_W-1:0] entry,
                                                input int                 has_answer,
                                                input int                 ok,
                                                input logic [RD_W-1:0]    read_data,
                                                input int                 length,
                                                input int                 empty_res);
      list_request_row row;
      row.op                 = op;
      row.position           = position;
      row.entry              = entry;
      row.has_answer         = (has_answer != 0);
      row.answer.ok          = (ok != 0);
      row.answer.read_data   = read_data;
      row.answer.length      = length[LEN_W-1:0];
      row.answer.empty_res   = (empty_res != 0);
      return row;
   endfunction

   // Presents one request beat, waits for the engine to take it, and records the
   // response it owes. The valid line is lowered only when an idle gap follows, so
   // it never gets two assignments in one time step.
   task automatic send_request(input logic [OP_W-1:0]    op,
                               input logic [POS_W-1:0]   position,
                               input logic [ENTRY_W-1:0] entry,
                               input bit                 has_answer,
                               input rsp_type            answer);
      int      idle;
      rsp_type predicted;
      idle = draw_idle(requests_sent);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_W'({entry, position, op});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(op, position, entry);
      owed_responses.push_back(has_answer ? answer : predicted);
      requests_sent++;
   endtask

   // Request side: the directed table first, then random traffic.
   initial begin
      op_mix_type          mix;
      int                  pick;
      int                  insert_share;
      int                  remove_share;
      int                  clear_share;
      logic [OP_W-1:0]     op;
      logic [POS_W-1:0]    position;
      logic [ENTRY_W-1:0]  entry;
      rsp_type             no_answer;
      list_request_row     row;

      no_answer = '0;

      // Refused requests on an empty list, then growth from the empty state.
      directed_rows.push_back(make_row(OP_GET,     7'd1, 32'h0, 1, 0, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_REMOVE,  7'd1, 32'h0, 1, 0, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_REPLACE, 7'd1, 32'h5, 1, 0, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_INSERT,  7'd0, 32'h1, 1, 0, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_INSERT,  7'd2, 32'h1, 1, 0, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_INSERT,  7'd1, 32'hFFFF_FFFF, 1, 1, 32'h0, 1, 0));
      directed_rows.push_back(make_row(OP_GET,     7'd1, 32'h0, 1, 1, 32'hFFFF_FFFF, 1, 0));
      directed_rows.push_back(make_row(OP_INSERT,  7'd1, 32'h0, 1, 1, 32'h0, 2, 0));
      directed_rows.push_back(make_row(OP_INSERT,  7'd3, 32'hA5A5_A5A5, 1, 1, 32'h0, 3, 0));
      directed_rows.push_back(make_row(OP_INSERT,  7'd2, 32'h1234_5678, 0, 0, 32'h0, 0, 0));
      // Positions outside the list, at both ends of the field and one past the tail.
      directed_rows.push_back(make_row(OP_GET,     7'd127, 32'h0, 1, 0, 32'h0, 4, 0));
      directed_rows.push_back(make_row(OP_GET,     7'd0,   32'h0, 1, 0, 32'h0, 4, 0));
      directed_rows.push_back(make_row(OP_GET,     7'd5,   32'h0, 1, 0, 32'h0, 4, 0));
      // Operation codes the engine does not implement.
      directed_rows.push_back(make_row(OP_BAD_LO,  7'd1, 32'hFFFF_FFFF, 1, 0, 32'h0, 4, 0));
      directed_rows.push_back(make_row(OP_BAD_MID, 7'd2, 32'h0,         1, 0, 32'h0, 4, 0));
      directed_rows.push_back(make_row(OP_BAD_HI,  7'd127, 32'hFFFF_FFFF, 1, 0, 32'h0, 4, 0));
      // Replace, read back, and removal at the head and at the tail.
      directed_rows.push_back(make_row(OP_REPLACE, 7'd4, 32'hDEAD_BEEF, 0, 0, 32'h0, 0, 0));
      directed_rows.push_back(make_row(OP_GET,     7'd4, 32'h0, 0, 0, 32'h0, 0, 0));
      directed_rows.push_back(make_row(OP_REMOVE,  7'd1, 32'h0, 0, 0, 32'h0, 0, 0));
      directed_rows.push_back(make_row(OP_REMOVE,  7'd3, 32'h0, 0, 0, 32'h0, 0, 0));
      directed_rows.push_back(make_row(OP_GET,     7'd2, 32'h0, 0, 0, 32'h0, 0, 0));
      // Clear ignores its position and entry, and works on an empty list too.
      directed_rows.push_back(make_row(OP_CLEAR,   7'd127, 32'hFFFF_FFFF, 1, 1, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_GET,     7'd1, 32'h0, 1, 0, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_CLEAR,   7'd0, 32'h0, 1, 1, 32'h0, 0, 1));
      directed_rows.push_back(make_row(OP_INSERT,  7'd1, 32'h8000_0001, 1, 1, 32'h0, 1, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.op, row.position, row.entry, row.has_answer, row.answer);
      end

      // Random traffic runs in phases that push the list toward full, toward
      // empty, or keep it level. The first phase always grows, so the list is
      // filled and inserts into a full list are tried early.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k < 150)
            mix = MIX_GROW;
         else
            mix = op_mix_type'((k / 120) % 3);
         case (mix)
            MIX_GROW: begin
               insert_share = 70;
               remove_share = 10;
               clear_share  = 0;
            end
            MIX_SHRINK: begin
               insert_share = 15;
               remove_share = 60;
               clear_share  = 1;
            end
            default: begin
               insert_share = 35;
               remove_share = 30;
               clear_share  = 2;
            end
         endcase

         pick = $urandom_range(0, 99);
         if (pick < 3)
            op = OP_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
         else if (pick < 3 + clear_share)
            op = OP_CLEAR;
         else if (pick < 3 + clear_share + insert_share)
            op = OP_INSERT;
         else if (pick < 3 + clear_share + insert_share + remove_share)
            op = OP_REMOVE;
         else if ($urandom_range(0, 1) == 0)
            op = OP_GET;
         else
            op = OP_REPLACE;

         // Mostly positions inside the list; the rest anywhere in the field.
         pick = $urandom_range(0, 99);
         if (pick < 15)
            position = POS_W'($urandom_range(0, 127));
         else if (op == OP_INSERT)
            position = POS_W'($urandom_range(1, list_len + 1));
         else if (list_len > 0)
            position = POS_W'($urandom_range(1, list_len));
         else
            position = POS_W'($urandom_range(0, 127));

         case ($urandom_range(0, 9))
            0:       entry = '0;
            1:       entry = '1;
            default: entry = ENTRY_W'($urandom());
         endcase

         send_request(op, position, entry, 1'b0, no_answer);
      end

      req_tvalid    <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Response side: stalls at random, then checks each beat against the oldest
   // owed response. The ready line is lowered only when a stall follows.
   initial begin
      int      stall;
      rsp_type actual;
      rsp_type expected;
      @(negedge reset);
      forever begin
         stall = draw_idle(responses_seen);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         actual = rsp_type'(rsp_tdata[RSP_FIELD_W-1:0]);
         responses_seen++;
         if (owed_responses.size() == 0) begin
            $display("%0t: response beat with none owed, got %h", $time, actual);
            error_count++;
         end else begin
            expected = owed_responses.pop_front();
            if (actual.ok !== expected.ok) begin
               $display("%0t: ok mismatch, expected %0b, got %0b",
                        $time, expected.ok, actual.ok);
               error_count++;
            end
            if (actual.read_data !== expected.read_data) begin
               $display("%0t: read_data mismatch, expected %h, got %h",
                        $time, expected.read_data, actual.read_data);
               error_count++;
            end
            if (actual.length !== expected.length) begin
               $display("%0t: length mismatch, expected %0d, got %0d",
                        $time, expected.length, actual.length);
               error_count++;
            end
            if (actual.empty_res !== expected.empty_res) begin
               $display("%0t: empty_res mismatch, expected %0b, got %0b",
                        $time, expected.empty_res, actual.empty_res);
               error_count++;
            end
         end
      end
   end

   // End of run: every request taken, every response seen, then a quiet stretch
   // long enough for the slowest operation so that a stray beat would show up.
   initial begin
      wait (stimulus_done);
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && owed_responses.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
